// File: design/lzwtcd_pkg.sv
`timescale 1ns / 1ps

package lzwtcd_pkg;

  localparam int TOKEN_COUNT_DEF   = 16384;
  localparam int POSITION_BITS_DEF = 24;

  localparam int BYTE_BITS = 8;
  localparam int CODE_BITS = 14;
  localparam int ACC_BITS  = 21;
  localparam int BITS_W    = 5;
  localparam int CFG_W     = 24;
  localparam int KIND_W    = 2;

  localparam logic [CODE_BITS-1:0] CODE_END        = 14'h3FFF;
  localparam logic [CODE_BITS-1:0] CODE_CLEAR      = 14'h3FFE;
  localparam logic [CODE_BITS-1:0] CODE_FIRST_COPY = 14'h0100;

  typedef enum logic [KIND_W-1:0] {
    KIND_LIT  = 2'd0,
    KIND_COPY = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

endpackage

// File: design/lzwtcd_ram.sv
`timescale 1ns / 1ps

module lzwtcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// File: design/lzw_token_copy_decoder.sv
`timescale 1ns / 1ps
// 14-bit LZW token decoder producing literal, copy and end commands.
// in_*  : one packed byte per transaction, MSB first; in_tuser starts a new stream.
// out_* : one command per transaction; out_tuser is the kind (literal, copy, end),
//         out_tlast marks the last command of the stream.
// cfg_* : write of total_length, taken whenever offered; write only while idle.
// Steps: a byte that only fills the bit accumulator is taken on its own. For a byte
// that completes a code, len[token] and origin are read, then len[origin] from a
// second copy of the length RAM, then the length is written back, output_position
// advanced and the result registered before the next byte is taken.
// Reset: a clearing pass writes every length entry with in_tready low. A clear code
// or start of stream reruns the pass over the length entries in use (up to the highest
// one written), one per cycle; start of stream then decodes its byte.
// Stall: one finished result waits in the output register while the next byte is
// taken; decoding stops behind it until out_tready.
module lzw_token_copy_decoder #(
  parameter int TOKEN_COUNT   = lzwtcd_pkg::TOKEN_COUNT_DEF,
  parameter int POSITION_BITS = lzwtcd_pkg::POSITION_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  input  logic [lzwtcd_pkg::BYTE_BITS-1:0]          in_tdata,   // packed_byte
  input  logic [0:0]                                in_tuser,   // start_of_stream
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // literal_value, copy_source, copy_length, write_position, zero fill
  output logic [((lzwtcd_pkg::BYTE_BITS + 3*POSITION_BITS + 7)/8)*8-1:0] out_tdata,
  output logic [lzwtcd_pkg::KIND_W-1:0]             out_tuser,  // kind
  output logic                                      out_tlast,  // done_res
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [lzwtcd_pkg::CFG_W-1:0]              cfg_data    // total_length
);

  import lzwtcd_pkg::*;

  localparam int PW     = POSITION_BITS;
  localparam int TIDX_W = $clog2(TOKEN_COUNT);
  localparam int TOK_W  = TIDX_W + 1;
  localparam int CMP_W  = (TOK_W > CODE_BITS) ? TOK_W : CODE_BITS;
  localparam int LW     = (PW > CFG_W) ? PW : CFG_W;
  localparam int ORG_W  = CODE_BITS + 1;

  // stream state
  logic [CFG_W-1:0]     total_r;
  logic [ACC_BITS-1:0]  acc_r;
  logic [BITS_W-1:0]    bits_r;
  logic [TOK_W-1:0]     tok_r;
  logic [PW-1:0]        pos_r;
  logic                 fin_r;
  logic                 pend_r;
  logic [BYTE_BITS-1:0] hold_r;

  // length clearing pass
  logic                 clr_busy_r;
  logic [TIDX_W-1:0]    clr_idx_r;
  logic [TOK_W-1:0]     hw_r;

  // lookup stage
  logic                 b_v_r;
  kind_t                b_kind_r;
  logic [BYTE_BITS-1:0] b_lit_r;
  logic [PW-1:0]        b_pos_r;
  logic [CODE_BITS-1:0] b_tok_r;
  logic                 b_vok_r;
  logic                 b_rec_r;
  logic                 b_fwd_r;

  // length stage
  logic                 c_v_r;
  kind_t                c_kind_r;
  logic [BYTE_BITS-1:0] c_lit_r;
  logic [PW-1:0]        c_pos_r;
  logic [CODE_BITS-1:0] c_tok_r;
  logic                 c_vok_r;
  logic                 c_ook_r;
  logic [PW-1:0]        c_src_r;
  logic [PW-1:0]        c_lenv_r;

  // output register
  logic                 out_v_r;
  kind_t                out_kind_r;
  logic [BYTE_BITS-1:0] out_lit_r;
  logic [PW-1:0]        out_src_r;
  logic [PW-1:0]        out_len_r;
  logic [PW-1:0]        out_pos_r;
  logic                 out_done_r;

  // RAM data
  logic [PW-1:0]        off_q;
  logic [ORG_W-1:0]     org_q;
  logic [PW-1:0]        len_a_q;
  logic [PW-1:0]        len_b_q;

  // decode
  logic                 in_fire;
  logic                 sos_fire;
  logic                 dec_fire;
  logic [BYTE_BITS-1:0] dec_byte;
  logic [ACC_BITS-1:0]  acc_cat;
  logic [BITS_W-1:0]    bits_sum;
  logic [BITS_W-1:0]    bits_left;
  logic [CODE_BITS-1:0] code;
  logic [CODE_BITS-1:0] tok_v;
  logic                 v_ok;
  logic                 rec_ok;
  logic [ACC_BITS-1:0]  acc_nxt;
  logic [BITS_W-1:0]    bits_nxt;
  logic [TOK_W-1:0]     tok_nxt;
  logic                 fin_set;
  logic                 clr_start;
  logic                 rec_we;
  logic                 b_load;
  kind_t                b_kind_nxt;
  logic                 b_rec_nxt;
  logic                 b_fwd_nxt;
  logic                 clr_go;

  // lookup stage logic
  logic                 org_flag;
  logic [CODE_BITS-1:0] org_idx;
  logic                 present;
  logic [PW-1:0]        src_b;
  logic                 ook_b;

  // length stage logic
  logic                 c_fire;
  logic [PW-1:0]        len_add;
  logic [PW:0]          len_sum;
  logic [PW-1:0]        len_sat;
  logic                 c_upd;
  logic [PW-1:0]        len_full;
  logic [LW-1:0]        rem_l;
  logic [LW-1:0]        len_l;
  logic [LW-1:0]        len_c;
  logic [PW-1:0]        c_len_out;
  logic [PW-1:0]        c_pos_adv;
  logic                 c_done;
  logic                 lw_we;
  logic [TOK_W-1:0]     tok_plus;
  logic                 len_we;
  logic [TIDX_W-1:0]    len_waddr;
  logic [PW-1:0]        len_wdata;

  assign cfg_ready = 1'b1;
  assign in_tready = !pend_r && !clr_busy_r && !b_v_r && !c_v_r;
  assign in_fire   = in_tvalid && in_tready;
  assign sos_fire  = in_fire && in_tuser[0];
  assign dec_fire  = (in_fire && !in_tuser[0]) || (pend_r && !clr_busy_r);
  assign dec_byte  = pend_r ? hold_r : in_tdata;

  always_comb begin
    acc_cat    = {acc_r[ACC_BITS-BYTE_BITS-1:0], dec_byte};
    bits_sum   = bits_r + BITS_W'(BYTE_BITS);
    bits_left  = bits_sum - BITS_W'(CODE_BITS);
    code       = CODE_BITS'(acc_cat >> bits_left);
    tok_v      = code - CODE_FIRST_COPY;
    v_ok       = CMP_W'(tok_v) < CMP_W'(TOKEN_COUNT);
    rec_ok     = tok_r < TOK_W'(TOKEN_COUNT);
    acc_nxt    = acc_r;
    bits_nxt   = bits_r;
    tok_nxt    = tok_r;
    fin_set    = 1'b0;
    clr_start  = 1'b0;
    rec_we     = 1'b0;
    b_load     = 1'b0;
    b_kind_nxt = KIND_END;
    if (dec_fire && !fin_r) begin
      if (LW'(pos_r) >= LW'(total_r)) begin
        fin_set = 1'b1;
        b_load  = 1'b1;
      end else begin
        acc_nxt  = acc_cat;
        bits_nxt = bits_sum;
        if (bits_sum >= BITS_W'(CODE_BITS)) begin
          bits_nxt = bits_left;
          if (code == CODE_END) begin
            fin_set = 1'b1;
            b_load  = 1'b1;
          end else if (code == CODE_CLEAR) begin
            tok_nxt   = '0;
            clr_start = (hw_r != '0);
          end else begin
            if (rec_ok) begin
              rec_we  = 1'b1;
              tok_nxt = tok_r + TOK_W'(1);
            end
            b_load     = 1'b1;
            b_kind_nxt = (code < CODE_FIRST_COPY) ? KIND_LIT : KIND_COPY;
          end
        end
      end
    end
    b_rec_nxt = CMP_W'(tok_v) < CMP_W'(tok_nxt);
    b_fwd_nxt = rec_we && (CMP_W'(tok_v) == CMP_W'(tok_r));
    clr_go    = clr_start || (sos_fire && (hw_r != '0));
  end

  always_comb begin
    org_flag = b_fwd_r ? 1'b1 : org_q[CODE_BITS];
    org_idx  = b_fwd_r ? b_tok_r : org_q[CODE_BITS-1:0];
    present  = b_vok_r && b_rec_r;
    src_b    = '0;
    if (present) begin
      src_b = b_fwd_r ? b_pos_r : off_q;
    end
    ook_b = present && org_flag && (CMP_W'(org_idx) < CMP_W'(TOKEN_COUNT));
  end

  always_comb begin
    c_fire   = c_v_r && (!out_v_r || out_tready);
    len_add  = c_ook_r ? len_b_q : PW'(1);
    len_sum  = {1'b0, c_lenv_r} + {1'b0, len_add};
    len_sat  = len_sum[PW] ? '1 : len_sum[PW-1:0];
    c_upd    = (c_kind_r == KIND_COPY) && c_vok_r && (c_lenv_r == PW'(1));
    len_full = !c_vok_r ? PW'(2) : (c_upd ? len_sat : c_lenv_r);
    rem_l    = LW'(total_r) - LW'(c_pos_r);
    len_l    = LW'(len_full);
    len_c    = (len_l > rem_l) ? rem_l : len_l;
    case (c_kind_r)
      KIND_LIT: begin
        c_len_out = '0;
        c_done    = (rem_l <= LW'(1));
        c_pos_adv = c_pos_r + PW'(1);
      end
      KIND_COPY: begin
        c_len_out = PW'(len_c);
        c_done    = (len_l >= rem_l);
        c_pos_adv = c_pos_r + PW'(len_c);
      end
      default: begin
        c_len_out = '0;
        c_done    = 1'b1;
        c_pos_adv = c_pos_r;
      end
    endcase
    lw_we     = c_fire && c_upd;
    tok_plus  = {1'b0, c_tok_r[TIDX_W-1:0]} + TOK_W'(1);
    len_we    = lw_we || clr_busy_r;
    len_waddr = clr_busy_r ? clr_idx_r : c_tok_r[TIDX_W-1:0];
    len_wdata = clr_busy_r ? PW'(1) : len_sat;
  end

  lzwtcd_ram #(.WIDTH(PW), .DEPTH(TOKEN_COUNT)) u_off (
    .clk   (clk),
    .we    (rec_we),
    .waddr (tok_r[TIDX_W-1:0]),
    .wdata (pos_r),
    .re    (b_load),
    .raddr (tok_v[TIDX_W-1:0]),
    .rdata (off_q)
  );

  lzwtcd_ram #(.WIDTH(ORG_W), .DEPTH(TOKEN_COUNT)) u_org (
    .clk   (clk),
    .we    (rec_we),
    .waddr (tok_r[TIDX_W-1:0]),
    .wdata ({(code >= CODE_FIRST_COPY), tok_v}),
    .re    (b_load),
    .raddr (tok_v[TIDX_W-1:0]),
    .rdata (org_q)
  );

  lzwtcd_ram #(.WIDTH(PW), .DEPTH(TOKEN_COUNT)) u_len_a (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .re    (b_load),
    .raddr (tok_v[TIDX_W-1:0]),
    .rdata (len_a_q)
  );

  lzwtcd_ram #(.WIDTH(PW), .DEPTH(TOKEN_COUNT)) u_len_b (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .re    (b_v_r),
    .raddr (org_idx[TIDX_W-1:0]),
    .rdata (len_b_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= '0;
      acc_r      <= '0;
      bits_r     <= '0;
      tok_r      <= '0;
      pos_r      <= '0;
      fin_r      <= 1'b0;
      pend_r     <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
      hw_r       <= TOK_W'(TOKEN_COUNT);
      b_v_r      <= 1'b0;
      c_v_r      <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        total_r <= cfg_data;
      end
      if (sos_fire) begin
        acc_r  <= '0;
        bits_r <= '0;
        tok_r  <= '0;
        pos_r  <= '0;
        fin_r  <= 1'b0;
        pend_r <= 1'b1;
      end else begin
        if (dec_fire) begin
          acc_r  <= acc_nxt;
          bits_r <= bits_nxt;
          tok_r  <= tok_nxt;
          pend_r <= 1'b0;
          if (fin_set) begin
            fin_r <= 1'b1;
          end
        end
        if (c_fire) begin
          if (c_done) begin
            fin_r <= 1'b1;
          end
          pos_r <= c_pos_adv;
        end
      end
      if (clr_busy_r) begin
        if (TOK_W'(clr_idx_r) + TOK_W'(1) == hw_r) begin
          clr_busy_r <= 1'b0;
          clr_idx_r  <= '0;
          hw_r       <= '0;
        end else begin
          clr_idx_r <= clr_idx_r + TIDX_W'(1);
        end
      end else if (clr_go) begin
        clr_busy_r <= 1'b1;
      end else if (lw_we && (tok_plus > hw_r)) begin
        hw_r <= tok_plus;
      end
      b_v_r <= b_load;
      if (b_v_r) begin
        c_v_r <= 1'b1;
      end else if (c_fire) begin
        c_v_r <= 1'b0;
      end
      if (c_fire) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sos_fire) begin
      hold_r <= in_tdata;
    end
    if (b_load) begin
      b_kind_r <= b_kind_nxt;
      b_lit_r  <= code[BYTE_BITS-1:0];
      b_pos_r  <= pos_r;
      b_tok_r  <= tok_v;
      b_vok_r  <= v_ok;
      b_rec_r  <= b_rec_nxt;
      b_fwd_r  <= b_fwd_nxt;
    end
    if (b_v_r) begin
      c_kind_r <= b_kind_r;
      c_lit_r  <= b_lit_r;
      c_pos_r  <= b_pos_r;
      c_tok_r  <= b_tok_r;
      c_vok_r  <= b_vok_r;
      c_ook_r  <= ook_b;
      c_src_r  <= src_b;
      c_lenv_r <= len_a_q;
    end
    if (c_fire) begin
      out_kind_r <= c_kind_r;
      out_lit_r  <= (c_kind_r == KIND_LIT) ? c_lit_r : '0;
      out_src_r  <= (c_kind_r == KIND_COPY) ? c_src_r : '0;
      out_len_r  <= c_len_out;
      out_pos_r  <= c_pos_r;
      out_done_r <= c_done;
    end
  end

  always_comb begin
    out_tdata                                  = '0;
    out_tdata[BYTE_BITS-1:0]                   = out_lit_r;
    out_tdata[BYTE_BITS+PW-1:BYTE_BITS]        = out_src_r;
    out_tdata[BYTE_BITS+2*PW-1:BYTE_BITS+PW]   = out_len_r;
    out_tdata[BYTE_BITS+3*PW-1:BYTE_BITS+2*PW] = out_pos_r;
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_done_r;

  a_stage_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(b_v_r && c_v_r))
    else $error("lookup and length stages both occupied");

  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!b_v_r && !c_v_r))
    else $error("clearing pass overlaps a code in flight");

  a_done_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (c_fire && c_done) |=> fin_r)
    else $error("last command did not finish the stream");

  a_tok_cap: assert property (@(posedge clk) disable iff (!rst_n)
    tok_r <= TOK_W'(TOKEN_COUNT))
    else $error("token count past table size");

endmodule
